/* src/column_filter_greater_than_assert.svh */
// Assertion macros used by the column filter serialiser.
`ifndef COLUMN_FILTER_GREATER_THAN_ASSERT_SVH
`define COLUMN_FILTER_GREATER_THAN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFGT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfgt: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CFGT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfgt: assertion failed");

`endif

/* src/cfgt_pkg.sv */
package cfgt_pkg;

    localparam int VALUE_W      = 64;
    localparam int LANE_COUNT_W = 4;
    localparam int ROW_W        = 32;
    localparam int COUNT_W      = 33;
    localparam int WORD_W       = 64;
    localparam int WORD_LOG     = 6;
    localparam int WIDX_W       = 26;
    localparam int RTYPE_W      = 2;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 64;
    localparam int M_TDATA_W    = 160;
    localparam int M_PAD_W      = M_TDATA_W - (ROW_W + WORD_W + WIDX_W + COUNT_W + 1);

    localparam int DEF_LANES       = 8;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE      = 1'b1;

    localparam logic MODE_INDEX = 1'b0;
    localparam logic MODE_MASK  = 1'b1;

    typedef enum logic [RTYPE_W-1:0] {
        RT_INDEX   = 2'd0,
        RT_MASK    = 2'd1,
        RT_SUMMARY = 2'd2
    } result_type_t;

    // Everything one beat produces, apart from its per-lane match bits.
    typedef struct packed {
        logic [ROW_W-1:0]   base_row;
        logic               mask_valid;
        logic [WORD_W-1:0]  mask_word;
        logic [WIDX_W-1:0]  mask_idx;
        logic               flush_valid;
        logic [WORD_W-1:0]  flush_word;
        logic [WIDX_W-1:0]  flush_idx;
        logic               last;
        logic [COUNT_W-1:0] count;
        logic               ovf;
    } beat_info_t;

endpackage

/* src/cfgt_lane.sv */
module cfgt_lane
    import cfgt_pkg::*;
(
    input  logic                      aclk,
    input  logic                      load,
    input  logic signed [VALUE_W-1:0] value,
    input  logic signed [VALUE_W-1:0] threshold,
    output logic                      gt
);

    logic gt_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            gt_reg <= (value > threshold);
        end
    end

    assign gt = gt_reg;

endmodule

/* src/cfgt_merge.sv */
module cfgt_merge
    import cfgt_pkg::*;
#(
    parameter int LANES = DEF_LANES,
    localparam int N_W  = $clog2(LANES + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  logic [LANES-1:0] gt,
    input  logic [N_W-1:0]   lane_n,
    input  logic             last,
    input  logic             output_mode,
    output logic             push,
    output logic [LANES-1:0] rec_idx,
    output beat_info_t       rec_info
);

    logic [COUNT_W-1:0]  rows_seen_reg, rows_seen_next;
    logic [COUNT_W-1:0]  match_total_reg, match_total_next;
    logic [WORD_W-1:0]   partial_reg, partial_next;
    logic                ovf_reg, ovf_next;

    logic [LANES-1:0]    lane_in;
    logic [LANES-1:0]    proc;
    logic [LANES-1:0]    hit;
    logic [COUNT_W-1:0]  row_i;
    logic [N_W-1:0]      proc_n;
    logic [N_W-1:0]      hit_n;
    logic [2*WORD_W-1:0] shifted;
    logic [WORD_W-1:0]   word_lo;
    logic [WORD_W-1:0]   word_hi;
    logic [WORD_LOG:0]   fill;
    logic                complete;
    logic                flush;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            row_i      = rows_seen_reg + COUNT_W'(i);
            lane_in[i] = (32'(i) < 32'(lane_n));
            proc[i]    = lane_in[i] && !row_i[COUNT_W-1];
        end
        hit     = gt & proc;
        proc_n  = N_W'($countones(proc));
        hit_n   = N_W'($countones(hit));
        shifted = (2*WORD_W)'(hit) << rows_seen_reg[WORD_LOG-1:0];
        word_lo = partial_reg | shifted[WORD_W-1:0];
        word_hi = shifted[2*WORD_W-1:WORD_W];
        fill    = {1'b0, rows_seen_reg[WORD_LOG-1:0]} + (WORD_LOG + 1)'(proc_n);
        complete = fill[WORD_LOG];

        rows_seen_next   = rows_seen_reg + COUNT_W'(proc_n);
        match_total_next = match_total_reg + COUNT_W'(hit_n);
        partial_next     = complete ? word_hi : word_lo;
        ovf_next         = ovf_reg || (|(lane_in & ~proc));
        flush            = last && (rows_seen_next[WORD_LOG-1:0] != '0);

        rec_idx              = (output_mode == MODE_INDEX) ? hit : '0;
        rec_info.base_row    = rows_seen_reg[ROW_W-1:0];
        rec_info.mask_valid  = (output_mode == MODE_MASK) && complete;
        rec_info.mask_word   = word_lo;
        rec_info.mask_idx    = rows_seen_reg[ROW_W-1:WORD_LOG];
        rec_info.flush_valid = (output_mode == MODE_MASK) && flush;
        rec_info.flush_word  = partial_next;
        rec_info.flush_idx   = rows_seen_next[ROW_W-1:WORD_LOG];
        rec_info.last        = last;
        rec_info.count       = match_total_next;
        rec_info.ovf         = ovf_next;

        push = fire && ((|rec_idx) || rec_info.mask_valid || last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_seen_reg   <= '0;
            match_total_reg <= '0;
            partial_reg     <= '0;
            ovf_reg         <= 1'b0;
        end else if (fire) begin
            if (last) begin
                rows_seen_reg   <= '0;
                match_total_reg <= '0;
                partial_reg     <= '0;
                ovf_reg         <= 1'b0;
            end else begin
                rows_seen_reg   <= rows_seen_next;
                match_total_reg <= match_total_next;
                partial_reg     <= partial_next;
                ovf_reg         <= ovf_next;
            end
        end
    end

endmodule

/* src/cfgt_queue.sv */
module cfgt_queue
    import cfgt_pkg::*;
#(
    parameter int LANES = DEF_LANES,
    parameter int DEPTH = DEF_QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [LANES-1:0] idx_in,
    input  beat_info_t       info_in,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [LANES-1:0] head_idx,
    output beat_info_t       head_info
);

    logic [LANES-1:0] idx_mem [DEPTH];
    beat_info_t       info_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (32'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            idx_mem[wr_ptr_reg]  <= idx_in;
            info_mem[wr_ptr_reg] <= info_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign full       = (32'(count_reg) == DEPTH);
    assign head_valid = (count_reg != '0);
    assign head_idx   = idx_mem[rd_ptr_reg];
    assign head_info  = info_mem[rd_ptr_reg];

endmodule

/* src/cfgt_serial.sv */
module cfgt_serial
    import cfgt_pkg::*;
#(
    parameter int LANES = DEF_LANES,
    localparam int SEL_W = (LANES > 1) ? $clog2(LANES) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  logic [LANES-1:0]   head_idx,
    input  beat_info_t         head_info,
    output logic               pop,
    input  logic               m_ready,
    output logic               m_valid,
    output result_type_t       m_type,
    output logic               m_last,
    output logic [ROW_W-1:0]   m_row,
    output logic [WORD_W-1:0]  m_word,
    output logic [WIDX_W-1:0]  m_widx,
    output logic [COUNT_W-1:0] m_count,
    output logic               m_ovf
);

`include "column_filter_greater_than_assert.svh"

    logic [LANES-1:0]   done_reg;
    logic               mask_done_reg;
    logic               flush_done_reg;
    logic               valid_reg;
    result_type_t       type_reg, type_next;
    logic               last_reg, last_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [WIDX_W-1:0]  widx_reg, widx_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               ovf_reg, ovf_next;

    logic [LANES-1:0]   pending;
    logic [LANES-1:0]   lowbit;
    logic [LANES-1:0]   rest;
    logic [SEL_W-1:0]   sel;
    logic               mask_pick;
    logic               flush_pick;
    logic               out_load;

    always_comb begin
        pending = head_idx & ~done_reg;
        lowbit  = pending & (~pending + LANES'(1));
        rest    = pending ^ lowbit;
        sel     = '0;
        for (int i = 0; i < LANES; i++) begin
            if (lowbit[i]) begin
                sel = sel | SEL_W'(i);
            end
        end

        row_next   = '0;
        word_next  = '0;
        widx_next  = '0;
        count_next = '0;
        ovf_next   = 1'b0;
        mask_pick  = 1'b0;
        flush_pick = 1'b0;
        if (|pending) begin
            type_next = RT_INDEX;
            row_next  = head_info.base_row + ROW_W'(sel);
            last_next = !(|rest) && !head_info.last;
        end else if (head_info.mask_valid && !mask_done_reg) begin
            mask_pick = 1'b1;
            type_next = RT_MASK;
            word_next = head_info.mask_word;
            widx_next = head_info.mask_idx;
            last_next = !head_info.last;
        end else if (head_info.flush_valid && !flush_done_reg) begin
            flush_pick = 1'b1;
            type_next  = RT_MASK;
            word_next  = head_info.flush_word;
            widx_next  = head_info.flush_idx;
            last_next  = !head_info.last;
        end else begin
            type_next  = RT_SUMMARY;
            count_next = head_info.count;
            ovf_next   = head_info.ovf;
            last_next  = 1'b1;
        end

        out_load = head_valid && (!valid_reg || m_ready);
        pop      = out_load && last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg       <= '0;
            mask_done_reg  <= 1'b0;
            flush_done_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end else begin
            if (out_load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
            if (pop) begin
                done_reg       <= '0;
                mask_done_reg  <= 1'b0;
                flush_done_reg <= 1'b0;
            end else if (out_load) begin
                done_reg       <= done_reg | lowbit;
                mask_done_reg  <= mask_done_reg || mask_pick;
                flush_done_reg <= flush_done_reg || flush_pick;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            type_reg  <= type_next;
            last_reg  <= last_next;
            row_reg   <= row_next;
            word_reg  <= word_next;
            widx_reg  <= widx_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_type  = type_reg;
    assign m_last  = last_reg;
    assign m_row   = row_reg;
    assign m_word  = word_reg;
    assign m_widx  = widx_reg;
    assign m_count = count_reg;
    assign m_ovf   = ovf_reg;

    `CFGT_ASSERT_NOW(a_summary_ends_run, aclk, aresetn, valid_reg && (type_reg == RT_SUMMARY), last_reg)
    `CFGT_ASSERT_NEXT(a_record_held, aclk, aresetn, out_load && !pop, head_valid)
    `CFGT_ASSERT_NEXT(a_pop_clears_progress, aclk, aresetn, pop,
                      (done_reg == '0) && !mask_done_reg && !flush_done_reg)

endmodule

/* src/column_filter_greater_than.sv */
// Greater-than column filter. Each input transaction carries up to LANES signed 64-bit rows
// (lane_count valid, lowest lanes first; tlast ends the stream); every row above the signed
// threshold register is selected. Output mode 0 yields one transaction per match holding its
// row number in ascending order; mode 1 yields each filled 64-bit selection word and, at the
// end of the stream, the partial word. The stream's final beat always ends with a summary
// transaction carrying the match count and the row overflow flag, and tlast marks the last
// transaction caused by each input beat. Configuration may only be written while the block is
// idle. One input beat is accepted per clock while the queue is not full; the LANES
// comparators and the merge stage run at that rate, and a queue of QUEUE_DEPTH beat records
// feeds a serialiser that sends one result per clock while m_axis_tready is high. A beat
// produces up to LANES + 1 results in index mode and at most three in mask mode, and its
// results pass from the comparator registers through the queue to the serialiser's register.
module column_filter_greater_than
    import cfgt_pkg::*;
#(
    parameter int LANES       = DEF_LANES,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    localparam int S_TDATA_W  = ((LANES * VALUE_W + LANE_COUNT_W + 7) / 8) * 8,
    localparam int N_W        = $clog2(LANES + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // value_0 .. value_{LANES-1}, lane_count, zero padding
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // row_index, mask_word, word_index, match_count, row_overflow, zero padding
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // result_type
    output logic [RTYPE_W-1:0]     m_axis_tuser,
    output logic                   m_axis_tlast
);

    logic signed [VALUE_W-1:0] threshold_reg;
    logic                      mode_reg;

    logic                    s_fire;
    logic                    s1_fire;
    logic                    s1_valid_reg;
    logic [N_W-1:0]          s1_n_reg;
    logic                    s1_last_reg;
    logic [LANES-1:0]        s1_gt;
    logic [LANE_COUNT_W-1:0] lane_count;

    logic             push;
    logic [LANES-1:0] rec_idx;
    beat_info_t       rec_info;
    logic             q_full;
    logic             pop;
    logic             head_valid;
    logic [LANES-1:0] head_idx;
    beat_info_t       head_info;

    result_type_t       out_type;
    logic [ROW_W-1:0]   out_row;
    logic [WORD_W-1:0]  out_word;
    logic [WIDX_W-1:0]  out_widx;
    logic [COUNT_W-1:0] res_count;
    logic               out_ovf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
            mode_reg      <= MODE_INDEX;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_THRESHOLD: begin
                    threshold_reg <= cfg_wdata;
                end
                CFG_MODE: begin
                    mode_reg <= cfg_wdata[0];
                end
                default: begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    assign lane_count    = s_axis_tdata[LANES*VALUE_W +: LANE_COUNT_W];
    assign s1_fire       = s1_valid_reg && !q_full;
    assign s_axis_tready = !s1_valid_reg || !q_full;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_n_reg    <= (32'(lane_count) > LANES) ? N_W'(LANES) : N_W'(lane_count);
            s1_last_reg <= s_axis_tlast;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        cfgt_lane u_lane (
            .aclk      (aclk),
            .load      (s_fire),
            .value     (s_axis_tdata[g*VALUE_W +: VALUE_W]),
            .threshold (threshold_reg),
            .gt        (s1_gt[g])
        );
    end

    cfgt_merge #(.LANES(LANES)) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (s1_fire),
        .gt          (s1_gt),
        .lane_n      (s1_n_reg),
        .last        (s1_last_reg),
        .output_mode (mode_reg),
        .push        (push),
        .rec_idx     (rec_idx),
        .rec_info    (rec_info)
    );

    cfgt_queue #(.LANES(LANES), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .idx_in     (rec_idx),
        .info_in    (rec_info),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_idx   (head_idx),
        .head_info  (head_info)
    );

    cfgt_serial #(.LANES(LANES)) u_serial (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_idx   (head_idx),
        .head_info  (head_info),
        .pop        (pop),
        .m_ready    (m_axis_tready),
        .m_valid    (m_axis_tvalid),
        .m_type     (out_type),
        .m_last     (m_axis_tlast),
        .m_row      (out_row),
        .m_word     (out_word),
        .m_widx     (out_widx),
        .m_count    (res_count),
        .m_ovf      (out_ovf)
    );

    assign m_axis_tdata = {{M_PAD_W{1'b0}}, out_ovf, res_count, out_widx, out_word, out_row};
    assign m_axis_tuser = out_type;

endmodule
